/* hdl/bts_pkg.sv */
// Shared types and constants for the bilinear texture sampler.
// Used by bts_coord, bts_blend and the top level; depends on nothing.
package bts_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int CHANNEL_BITS = 16;
  localparam int NUM_CH       = 4;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int TEXEL_W   = NUM_CH * CHANNEL_BITS;
  localparam int BANK_AW   = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

  localparam int SIZE_W   = 7;
  localparam int CCOUNT_W = 3;
  localparam int COORD_W  = 20;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W   = 8;
  localparam int WEIGHT_W = 2 * FRAC_W + 1;
  localparam int PROD_W   = CHANNEL_BITS + WEIGHT_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int UV_W     = COORD_W + SIZE_W + 1;
  localparam int IDX_W    = UV_W - FRAC_BITS;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = TEXEL_W;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [SIZE_W-1:0]   MAX_WIDTH_C  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0]   MAX_HEIGHT_C = SIZE_W'(MAX_HEIGHT);
  localparam logic [CCOUNT_W-1:0] CCOUNT_RST   = CCOUNT_W'(NUM_CH);

  typedef enum logic [1:0] {
    REG_TEX_WIDTH     = 2'd0,
    REG_TEX_HEIGHT    = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef struct packed {
    action_t                    action;
    logic [COL_W-1:0]           texel_col;
    logic [ROW_W-1:0]           texel_row;
    logic [TEXEL_W-1:0]         texel;     // red in the low channel
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
  } item_t;

  // texture bank access for one pipeline slot
  typedef struct packed {
    logic                         we;
    logic [1:0]                   wbank;
    logic [BANK_AW-1:0]           waddr;
    logic [TEXEL_W-1:0]           wdata;
    logic                         re;
    logic [3:0][BANK_AW-1:0]      raddr;
  } mem_req_t;

  // per-sample side info that travels with the bank reads
  typedef struct packed {
    logic                         valid;
    logic [3:0][1:0]              sel;
    logic [3:0][WEIGHT_W-1:0]     weight;
  } tap_t;

  // zero reads as one, oversize saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] s;
    if (r == '0) begin
      s = SIZE_W'(1);
    end else if (r > maxv) begin
      s = maxv;
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

/* hdl/bts_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bts_coord.sv */
// Coordinate stages: scales coordinates, then floors, clamps, builds bank
// addresses, bilinear weights and texel write requests. Depends on bts_pkg.
module bts_coord (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  bts_pkg::item_t                in_item,
  input  logic [bts_pkg::SIZE_W-1:0]    tex_width,
  input  logic [bts_pkg::SIZE_W-1:0]    tex_height,
  output bts_pkg::mem_req_t             mem_req,
  output bts_pkg::tap_t                 tap
);
  import bts_pkg::*;

  function automatic logic [IDX_W:0] clamp_idx(input logic signed [IDX_W:0] i,
                                               input logic [SIZE_W-1:0] size);
    logic signed [IDX_W:0] lim;
    logic [IDX_W:0]        r;
    lim = $signed({{(IDX_W + 1 - SIZE_W){1'b0}}, size});
    if (i < 0) begin
      r = '0;
    end else if (i >= lim) begin
      r = (IDX_W + 1)'(size - SIZE_W'(1));
    end else begin
      r = i;
    end
    return r;
  endfunction

  logic [SIZE_W-1:0] w_eff, h_eff;
  logic signed [UV_W-1:0] u_prod, v_prod;

  logic                   s1_valid;
  action_t                s1_action;
  logic [COL_W-1:0]       s1_col;
  logic [ROW_W-1:0]       s1_row;
  logic [TEXEL_W-1:0]     s1_texel;
  logic signed [UV_W-1:0] s1_u, s1_v;

  assign w_eff = eff_size(tex_width, MAX_WIDTH_C);
  assign h_eff = eff_size(tex_height, MAX_HEIGHT_C);

  assign u_prod = $signed(in_item.coord_u) * $signed({1'b0, w_eff});
  assign v_prod = $signed(in_item.coord_v) * $signed({1'b0, h_eff});

  // stage 1: u = coord*size - 0.5 in Q.16
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s1_action <= in_item.action;
      s1_col    <= in_item.texel_col;
      s1_row    <= in_item.texel_row;
      s1_texel  <= in_item.texel;
      s1_u      <= u_prod - UV_W'(32768);
      s1_v      <= v_prod - UV_W'(32768);
    end
  end

  // stage 2 logic: floor, clamp, bank addressing, weights
  logic signed [IDX_W:0]  iu, iv, iu1, iv1;
  logic [IDX_W:0]         cu0, cu1, cv0, cv1;
  logic [COL_W-1:0]       i0, i1;
  logic [ROW_W-1:0]       j0, j1;
  logic [FRAC_W-1:0]      fu, fv;
  logic [FRAC_W:0]        wu0, wv0, wu1, wv1;

  assign iu  = {s1_u[UV_W-1], s1_u[UV_W-1:FRAC_BITS]};
  assign iv  = {s1_v[UV_W-1], s1_v[UV_W-1:FRAC_BITS]};
  assign iu1 = iu + (IDX_W + 1)'(1);
  assign iv1 = iv + (IDX_W + 1)'(1);

  assign cu0 = clamp_idx(iu, w_eff);
  assign cu1 = clamp_idx(iu1, w_eff);
  assign cv0 = clamp_idx(iv, h_eff);
  assign cv1 = clamp_idx(iv1, h_eff);
  assign i0  = cu0[COL_W-1:0];
  assign i1  = cu1[COL_W-1:0];
  assign j0  = cv0[ROW_W-1:0];
  assign j1  = cv1[ROW_W-1:0];

  assign fu  = s1_u[FRAC_BITS-1 -: FRAC_W];
  assign fv  = s1_v[FRAC_BITS-1 -: FRAC_W];
  assign wu1 = {1'b0, fu};
  assign wv1 = {1'b0, fv};
  assign wu0 = (FRAC_W + 1)'(1 << FRAC_W) - wu1;
  assign wv0 = (FRAC_W + 1)'(1 << FRAC_W) - wv1;

  // Texels are banked by (row parity, column parity). Unclamped neighbors
  // differ in parity; at an edge both neighbors are the same texel.
  always_comb begin
    logic [COL_W-1:0] csel;
    logic [ROW_W-1:0] rsel;
    mem_req.we    = s1_valid && (s1_action == ACT_WRITE);
    mem_req.wbank = {s1_row[0], s1_col[0]};
    mem_req.waddr = {s1_row[ROW_W-1:1], s1_col[COL_W-1:1]};
    mem_req.wdata = s1_texel;
    mem_req.re    = s1_valid && (s1_action == ACT_SAMPLE);
    for (int b = 0; b < 4; b++) begin
      csel = (i0[0] == b[0]) ? i0 : i1;
      rsel = (j0[0] == b[1]) ? j0 : j1;
      mem_req.raddr[b] = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
    end
  end

  // operands widened first: 256*256 needs all WEIGHT_W bits
  always_comb begin
    tap.valid     = s1_valid && (s1_action == ACT_SAMPLE);
    tap.sel[0]    = {j0[0], i0[0]};
    tap.sel[1]    = {j0[0], i1[0]};
    tap.sel[2]    = {j1[0], i0[0]};
    tap.sel[3]    = {j1[0], i1[0]};
    tap.weight[0] = WEIGHT_W'(wu0) * WEIGHT_W'(wv0);
    tap.weight[1] = WEIGHT_W'(wu1) * WEIGHT_W'(wv0);
    tap.weight[2] = WEIGHT_W'(wu0) * WEIGHT_W'(wv1);
    tap.weight[3] = WEIGHT_W'(wu1) * WEIGHT_W'(wv1);
  end

endmodule

/* hdl/bts_blend.sv */
// Blend stages: picks the four neighbor texels out of the banks, weights
// them (registered products), then sums and masks channels. Depends on bts_pkg.
module bts_blend (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  bts_pkg::tap_t                         tap,
  input  logic [3:0][bts_pkg::TEXEL_W-1:0]      bank_data,
  input  logic [bts_pkg::CCOUNT_W-1:0]          channel_count,
  output logic                                  res_valid,
  output logic [bts_pkg::TEXEL_W-1:0]           res_data
);
  import bts_pkg::*;

  logic [3:0][NUM_CH-1:0][PROD_W-1:0] prod_next, prod;
  logic                               s3_valid;

  always_comb begin
    logic [TEXEL_W-1:0] tx;
    for (int k = 0; k < 4; k++) begin
      tx = bank_data[tap.sel[k]];
      for (int c = 0; c < NUM_CH; c++) begin
        prod_next[k][c] = PROD_W'(tx[c*CHANNEL_BITS +: CHANNEL_BITS])
                        * PROD_W'(tap.weight[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= tap.valid;
      prod     <= prod_next;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] acc;
    for (int c = 0; c < NUM_CH; c++) begin
      acc = SUM_W'(prod[0][c]) + SUM_W'(prod[1][c]) + SUM_W'(prod[2][c])
          + SUM_W'(prod[3][c]);
      if (channel_count > CCOUNT_W'(c)) begin
        res_data[c*CHANNEL_BITS +: CHANNEL_BITS] = acc[FRAC_BITS +: CHANNEL_BITS];
      end else begin
        res_data[c*CHANNEL_BITS +: CHANNEL_BITS] = '0;
      end
    end
  end

  assign res_valid = s3_valid;

endmodule

/* hdl/bilinear_texture_sampler_core.sv */
// Top level of the bilinear texture sampler: stream ports, APB registers,
// four texel banks and the pipeline. Depends on bts_pkg, bts_ram, bts_coord, bts_blend.
//
//  channel  | dir | transfer carries
//  ---------+-----+---------------------------------------------------
//  s_*      | in  | one write texel or one sample request (tuser=action)
//  m_*      | out | one filtered RGBA result per sample request
//  APB      | in  | tex_width @0x0, tex_height @0x4, channel_count @0x8
//
// One item per cycle unless the output stalls. A sample result reaches m_tvalid
// through five register stages: input register, coordinate scale, clamp and bank
// read, weighted products, sum into the output register. The rate rests on the
// four parity banks, each with one read and one write port, so the 2x2 footprint
// is read in a single access. Write items take their bank's write port and give
// no result. Reset clears valid bits and sets the registers to 64, 64, 4; the
// texture is undefined until written. When the output register holds a result
// that is not taken, every stage holds.
module bilinear_texture_sampler_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // texel_col, texel_row, in_red, in_green, in_blue, in_alpha, coord_u, coord_v
  input  logic [bts_pkg::IN_TDATA_W-1:0]     s_tdata,
  // action
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [bts_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bts_pkg::PADDR_W-1:0]        paddr,
  input  logic [bts_pkg::PDATA_W-1:0]        pwdata,
  output logic [bts_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import bts_pkg::*;

  logic [SIZE_W-1:0]   tex_width, tex_height;
  logic [CCOUNT_W-1:0] channel_count;
  reg_idx_t            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width     <= MAX_WIDTH_C;
      tex_height    <= MAX_HEIGHT_C;
      channel_count <= CCOUNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_TEX_WIDTH:     tex_width     <= pwdata[SIZE_W-1:0];
        REG_TEX_HEIGHT:    tex_height    <= pwdata[SIZE_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TEX_WIDTH:     prdata = PDATA_W'(tex_width);
      REG_TEX_HEIGHT:    prdata = PDATA_W'(tex_height);
      REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count);
      default:           prdata = '0;
    endcase
  end

  // whole pipeline moves unless the output register is full and stalled
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  item_t in_item, s0_item;
  logic  s0_valid;

  always_comb begin
    in_item.action    = action_t'(s_tuser);
    in_item.texel_col = s_tdata[5:0];
    in_item.texel_row = s_tdata[11:6];
    in_item.texel     = s_tdata[75:12];
    in_item.coord_u   = $signed(s_tdata[95:76]);
    in_item.coord_v   = $signed(s_tdata[115:96]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= s_tvalid;
      s0_item  <= in_item;
    end
  end

  mem_req_t mem_req;
  tap_t     tap, s2_tap;

  bts_coord u_coord (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (s0_valid),
    .in_item    (s0_item),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .mem_req    (mem_req),
    .tap        (tap)
  );

  logic [3:0][TEXEL_W-1:0] bank_data;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (advance && mem_req.we && (mem_req.wbank == 2'(b))),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (advance && mem_req.re),
      .raddr (mem_req.raddr[b]),
      .rdata (bank_data[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tap.valid <= 1'b0;
    end else if (advance) begin
      s2_tap <= tap;
    end
  end

  logic               res_valid;
  logic [TEXEL_W-1:0] res_data;

  bts_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .tap           (s2_tap),
    .bank_data     (bank_data),
    .channel_count (channel_count),
    .res_valid     (res_valid),
    .res_data      (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
      m_tdata  <= res_data;
    end
  end

endmodule
